@@ hw/rtl/sset_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sset_pkg: shared types and constants of the sorted set unit
// Field widths, request and status codes, cell control and read group types.
// ---------------------------------------------------------------------------
package sset_pkg;

   localparam int CAPACITY   = 64;
   localparam int VAL_W      = 32;
   localparam int KIND_W     = 2;
   localparam int POS_W      = 6;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 7;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int GROUP_SIZE = 8;
   localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD_CELLS  = NUM_GROUPS * GROUP_SIZE;
   localparam int PAD_IDX_W  = $clog2(PAD_CELLS);
   localparam int IDX_CMP_W  = (PAD_IDX_W > POS_W) ? PAD_IDX_W : POS_W;

   typedef logic signed [VAL_W-1:0] val_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_READ   = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_DELETED   = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_CLEARED   = 3'd5,
      ST_READ_OK   = 3'd6,
      ST_BAD_POS   = 3'd7
   } rsp_status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_EVAL,
      CELL_INSERT,
      CELL_DELETE,
      CELL_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      val_type     key;
   } cell_ctl_type;

   // What a cell shows its neighbors
   typedef struct packed {
      val_type value;
      logic    valid;
      logic    gt;    // empty, or entry above key
      logic    eq;    // valid and entry equals key
   } cell_out_type;

   typedef struct packed {
      logic    hit;
      val_type data;
   } grp_rd_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_FINISH
   } fsm_state_type;

endpackage

`default_nettype wire

@@ hw/rtl/sset_cell.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sset_cell: one slot of the sorted chain
// Holds one entry and its valid bit, compares against the key and shifts
// toward either neighbor on insert or delete.
// ---------------------------------------------------------------------------
module sset_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sset_pkg::cell_ctl_type ctl,
   input  wire sset_pkg::cell_out_type left_cell,
   input  wire sset_pkg::cell_out_type right_cell,
   output      sset_pkg::cell_out_type this_cell
);
   import sset_pkg::*;

   val_type value_ff, value_in;
   logic    valid_ff, valid_in;
   logic    gt_ff, gt_in;
   logic    ge_ff, ge_in;
   logic    eq_ff, eq_in;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      gt_in    = gt_ff;
      ge_in    = ge_ff;
      eq_in    = eq_ff;
      case (ctl.op)
         CELL_HOLD: begin
         end
         CELL_EVAL: begin
            gt_in = !valid_ff || (value_ff > ctl.key);
            ge_in = valid_ff && (value_ff >= ctl.key);
            eq_in = valid_ff && (value_ff == ctl.key);
         end
         CELL_INSERT: begin
            // first slot above key takes the key, the rest move up one
            if (gt_ff) begin
               if (left_cell.gt) begin
                  value_in = left_cell.value;
                  valid_in = left_cell.valid;
               end else begin
                  value_in = ctl.key;
                  valid_in = 1'b1;
               end
            end
         end
         CELL_DELETE: begin
            // the match and everything above it move down one
            if (ge_ff) begin
               value_in = right_cell.value;
               valid_in = right_cell.valid;
            end
         end
         CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         gt_ff    <= 1'b0;
         ge_ff    <= 1'b0;
         eq_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         gt_ff    <= gt_in;
         ge_ff    <= ge_in;
         eq_ff    <= eq_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign this_cell.value = value_ff;
   assign this_cell.valid = valid_ff;
   assign this_cell.gt    = gt_ff;
   assign this_cell.eq    = eq_ff;

endmodule

`default_nettype wire

@@ hw/rtl/sset_group.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sset_group: first level of the read select tree
// Registers the entry of whichever of its cells matches the read position.
// ---------------------------------------------------------------------------
module sset_group (
   input  wire logic                         clock,
   input  wire logic                         load,
   input  wire logic [sset_pkg::GROUP_SIZE-1:0] hits,
   input  wire sset_pkg::val_type            vals [sset_pkg::GROUP_SIZE],
   output      sset_pkg::grp_rd_type         rd
);
   import sset_pkg::*;

   grp_rd_type rd_ff, rd_in;

   always_comb begin
      rd_in.hit  = |hits;
      rd_in.data = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
         rd_in.data = rd_in.data | (vals[j] & {VAL_W{hits[j]}});
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rd_ff <= rd_in;
      end
   end

   assign rd = rd_ff;

endmodule

`default_nettype wire

@@ hw/rtl/sorted_set_insert_delete_unit.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sorted_set_insert_delete_unit: sorted set of distinct signed words
// Insert, delete, clear and read by position over a chain of compare cells
// that keeps the entries in ascending signed order.
// ---------------------------------------------------------------------------
//
//  channel   ports                                        handshake
//  --------  -------------------------------------------  -------------------
//  request   req_kind, req_item_value, req_position       start && !busy
//  result    rsp_status, rsp_read_data, rsp_entry_count   rsp_strobe, 1 cycle
//
//  Each item runs through these steps from accept to the next possible accept:
//  compare (every cell checks its entry against the key, read groups
//  select), then commit (cells shift one slot, count and result update),
//  then the result shows on rsp_* under a one-cycle strobe, busy already low.
//  The sequencer below sets these steps; every kind of request takes them all.
//  Reset empties the set at once (valid bits and count clear); no sweep.
//  The receiver cannot stall: a result is gone after its strobe cycle.
//
module sorted_set_insert_delete_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output      logic                            busy,
   input  wire logic [sset_pkg::KIND_W-1:0]     req_kind,
   input  wire logic signed [sset_pkg::VAL_W-1:0] req_item_value,
   input  wire logic [sset_pkg::POS_W-1:0]      req_position,
   output      logic                            rsp_strobe,
   output      logic [sset_pkg::STATUS_W-1:0]   rsp_status,
   output      logic signed [sset_pkg::VAL_W-1:0] rsp_read_data,
   output      logic [sset_pkg::COUNT_W-1:0]    rsp_entry_count
);
   import sset_pkg::*;

   // sequencer
   fsm_state_type state_ff, state_in;

   // latched request
   req_kind_type          kind_ff;
   val_type               key_ff;
   logic [POS_W-1:0]      pos_ff;

   // set size
   logic [CNT_W-1:0]      count_ff, count_in;

   // result registers
   logic                  strobe_ff, strobe_in;
   rsp_status_type        status_ff, status_in;
   val_type               data_ff, data_in;

   // cell chain
   cell_ctl_type          cell_ctl;
   cell_out_type          cells [CAPACITY];
   logic [CAPACITY-1:0]   cell_valid;
   logic [CAPACITY-1:0]   cell_eq;

   // read tree
   val_type               pad_val [PAD_CELLS];
   logic [PAD_CELLS-1:0]  pad_hit;
   grp_rd_type            grp_rd [NUM_GROUPS];
   logic                  grp_load;

   logic                  accept;
   logic                  any_eq;
   logic                  any_hit;
   val_type               hit_data;
   logic                  set_full;

   assign accept = start && (state_ff == FSM_IDLE);
   assign busy   = (state_ff != FSM_IDLE);

   // ---------------- cell chain ----------------
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_out_type left_cell, right_cell;

      if (i == 0) begin : g_first
         assign left_cell = '0;   // gt low: the head, when above the key, takes the key
      end else begin : g_mid_l
         assign left_cell = cells[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_cell = '0;  // shifting past the tail brings in an empty slot
      end else begin : g_mid_r
         assign right_cell = cells[i+1];
      end

      sset_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .left_cell  (left_cell),
         .right_cell (right_cell),
         .this_cell  (cells[i])
      );

      assign cell_valid[i] = cells[i].valid;
      assign cell_eq[i]    = cells[i].eq;
   end

   // ---------------- read select tree ----------------
   for (genvar i = 0; i < PAD_CELLS; i++) begin : g_pad
      if (i < CAPACITY) begin : g_real
         assign pad_val[i] = cells[i].value;
         assign pad_hit[i] = cells[i].valid &&
                             (IDX_CMP_W'(i) == IDX_CMP_W'(pos_ff));
      end else begin : g_fill
         assign pad_val[i] = '0;
         assign pad_hit[i] = 1'b0;
      end
   end

   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
      val_type grp_vals [GROUP_SIZE];

      for (genvar j = 0; j < GROUP_SIZE; j++) begin : g_tap
         assign grp_vals[j] = pad_val[g*GROUP_SIZE + j];
      end

      sset_group u_group (
         .clock (clock),
         .load  (grp_load),
         .hits  (pad_hit[g*GROUP_SIZE +: GROUP_SIZE]),
         .vals  (grp_vals),
         .rd    (grp_rd[g])
      );
   end

   always_comb begin
      any_hit  = 1'b0;
      hit_data = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         any_hit  = any_hit | grp_rd[g].hit;
         hit_data = hit_data | grp_rd[g].data;
      end
   end

   // duplicate / match seen by any cell in the compare cycle
   assign any_eq   = |cell_eq;
   assign set_full = (count_ff == CNT_W'(CAPACITY));

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FSM_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind_type'(req_kind);
         key_ff  <= req_item_value;
         pos_ff  <= req_position;
      end
      if (state_ff == FSM_FINISH) begin
         status_ff <= status_in;
         data_ff   <= data_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      strobe_in    = 1'b0;
      status_in    = status_ff;
      data_in      = '0;
      grp_load     = 1'b0;
      cell_ctl.op  = CELL_HOLD;
      cell_ctl.key = key_ff;

      case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            cell_ctl.op = CELL_EVAL;
            grp_load    = 1'b1;
            state_in    = FSM_FINISH;
         end
         FSM_FINISH: begin
            strobe_in = 1'b1;
            state_in  = FSM_IDLE;
            case (kind_ff)
               KIND_INSERT: begin
                  if (any_eq) begin
                     status_in = ST_DUPLICATE;
                  end else if (set_full) begin
                     status_in = ST_FULL;
                  end else begin
                     cell_ctl.op = CELL_INSERT;
                     count_in    = count_ff + 1'b1;
                     status_in   = ST_INSERTED;
                  end
               end
               KIND_DELETE: begin
                  if (any_eq) begin
                     cell_ctl.op = CELL_DELETE;
                     count_in    = count_ff - 1'b1;
                     status_in   = ST_DELETED;
                  end else begin
                     status_in = ST_NOT_FOUND;
                  end
               end
               KIND_CLEAR: begin
                  cell_ctl.op = CELL_CLEAR;
                  count_in    = '0;
                  status_in   = ST_CLEARED;
               end
               KIND_READ: begin
                  if (any_hit) begin
                     status_in = ST_READ_OK;
                     data_in   = hit_data;
                  end else begin
                     status_in = ST_BAD_POS;
                  end
               end
               default: begin
                  status_in = ST_BAD_POS;
               end
            endcase
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_read_data   = data_ff;
   assign rsp_entry_count = COUNT_W'(count_ff);

   // ---------------- checks ----------------
   // valid slots always number exactly the held count
   a_valid_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == count_ff)
      else $error("cell valid bits disagree with count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("count above capacity");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held more than one cycle");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (status_ff == ST_INSERTED)) |->
         (count_ff == $past(count_ff) + 1'b1))
      else $error("insert reported without count growth");

   // strobe is taken after the accept once EXEC and FINISH have passed
   a_accept_to_strobe: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##2 rsp_strobe)
      else $error("result not produced three cycles after accept");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the sorted set insert/delete unit
// A walked table of directed requests, then episodes of random requests
// (fill, grow, shrink, mixed, noise). Each result is compared with a hand-written
// result or with a shadow copy of the set kept in a queue.
// ---------------------------------------------------------------------------
module tb_top;
   import sset_pkg::*;

   localparam int RANDOM_ITEMS = 1850;
   localparam int DRAIN_LIMIT  = 200;

   typedef struct packed {
      rsp_status_type          status;
      val_type                 data;
      logic [COUNT_W-1:0]      count;
   } set_result_type;

   // One row of the directed table; typed rows carry a hand-written result
   typedef struct packed {
      req_kind_type            kind;
      val_type                 item_val;
      logic [POS_W-1:0]        pos;
      logic                    typed;
      set_result_type          want;
   } directed_row_type;

   localparam int NUM_ROWS = 25;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [KIND_W-1:0]          req_kind;
   logic signed [VAL_W-1:0]    req_item_value;
   logic [POS_W-1:0]           req_position;
   logic                       rsp_strobe;
   logic [STATUS_W-1:0]        rsp_status;
   logic signed [VAL_W-1:0]    rsp_read_data;
   logic [COUNT_W-1:0]         rsp_entry_count;

   val_type                    shadow_set[$];      // ascending, like the unit
   set_result_type             pending_results[$]; // oldest first
   int                         error_count;
   int                         items_sent;
   int                         results_checked;
   int                         status_seen[8];

   // Directed requests: empty-set corners, signed extremes, duplicates,
   // read past the end, alternating bit patterns, clear of an empty set.
   directed_row_type directed_rows[NUM_ROWS] = '{
      '{KIND_READ,   32'sd0,          6'd0,  1'b1, '{ST_BAD_POS,   32'sd0, 7'd0}},
      '{KIND_DELETE, 32'sd5,          6'd0,  1'b1, '{ST_NOT_FOUND, 32'sd0, 7'd0}},
      '{KIND_CLEAR,  32'sd0,          6'd0,  1'b1, '{ST_CLEARED,   32'sd0, 7'd0}},
      '{KIND_INSERT, 32'sh7FFF_FFFF,  6'd0,  1'b1, '{ST_INSERTED,  32'sd0, 7'd1}},
      '{KIND_INSERT, 32'sh8000_0000,  6'd0,  1'b1, '{ST_INSERTED,  32'sd0, 7'd2}},
      '{KIND_INSERT, 32'sh8000_0000,  6'd0,  1'b1, '{ST_DUPLICATE, 32'sd0, 7'd2}},
      '{KIND_READ,   32'sd0,          6'd0,  1'b1,
        '{ST_READ_OK, 32'sh8000_0000, 7'd2}},
      '{KIND_READ,   32'sd0,          6'd1,  1'b1,
        '{ST_READ_OK, 32'sh7FFF_FFFF, 7'd2}},
      '{KIND_READ,   32'sd0,          6'd63, 1'b1, '{ST_BAD_POS,   32'sd0, 7'd2}},
      '{KIND_READ,   32'sd0,          6'd2,  1'b1, '{ST_BAD_POS,   32'sd0, 7'd2}},
      '{KIND_INSERT, -32'sd1,         6'd0,  1'b0, '0},
      '{KIND_INSERT, 32'sd0,          6'd0,  1'b0, '0},
      '{KIND_INSERT, 32'sd1,          6'd0,  1'b0, '0},
      '{KIND_READ,   32'sd0,          6'd1,  1'b0, '0},
      '{KIND_DELETE, 32'sh7FFF_FFFF,  6'd0,  1'b0, '0},
      '{KIND_DELETE, 32'sd12345,      6'd0,  1'b0, '0},
      '{KIND_DELETE, 32'sh8000_0000,  6'd0,  1'b0, '0},
      '{KIND_READ,   32'sd0,          6'd0,  1'b0, '0},
      '{KIND_INSERT, 32'sh5555_5555,  6'd0,  1'b0, '0},
      '{KIND_INSERT, 32'shAAAA_AAAA,  6'd0,  1'b0, '0},
      '{KIND_READ,   32'sd0,          6'd42, 1'b0, '0},
      '{KIND_READ,   32'sd0,          6'd21, 1'b0, '0},
      '{KIND_CLEAR,  32'sd0,          6'd0,  1'b1, '{ST_CLEARED,   32'sd0, 7'd0}},
      '{KIND_CLEAR,  32'sd0,          6'd0,  1'b1, '{ST_CLEARED,   32'sd0, 7'd0}},
      '{KIND_READ,   32'sd0,          6'd0,  1'b1, '{ST_BAD_POS,   32'sd0, 7'd0}}
   };

   // Values near the ends of the signed range and around zero
   val_type corner_values[6] = '{32'sh8000_0000, 32'sh8000_0001, 32'sh7FFF_FFFF,
                                 32'sh7FFF_FFFE, 32'sd0, -32'sd1};

   sorted_set_insert_delete_unit uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_item_value  (req_item_value),
      .req_position    (req_position),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_read_data   (rsp_read_data),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Applies one request to the shadow set and returns what the unit owes.
   // Order is signed: val_type is a signed vector.
   function automatic set_result_type apply_to_shadow(input req_kind_type kind,
                                                      input val_type item_val,
                                                      input logic [POS_W-1:0] pos);
      set_result_type res;
      int             slot;
      bit             found;
      res.data = '0;
      slot = 0;
      while (slot < shadow_set.size() && shadow_set[slot] < item_val)
         slot++;
      found = (slot < shadow_set.size()) && (shadow_set[slot] == item_val);
      case (kind)
         KIND_INSERT: begin
            if (found) begin
               res.status = ST_DUPLICATE;  // wins over full
            end else if (shadow_set.size() >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               shadow_set.insert(slot, item_val);
               res.status = ST_INSERTED;
            end
         end
         KIND_DELETE: begin
            if (found) begin
               shadow_set.delete(slot);
               res.status = ST_DELETED;
            end else begin
               res.status = ST_NOT_FOUND;
            end
         end
         KIND_CLEAR: begin
            shadow_set.delete();
            res.status = ST_CLEARED;
         end
         default: begin
            if (int'(pos) < shadow_set.size()) begin
               res.data   = shadow_set[pos];
               res.status = ST_READ_OK;
            end else begin
               res.status = ST_BAD_POS;  // data stays zero
            end
         end
      endcase
      res.count = COUNT_W'(shadow_set.size());
      return res;
   endfunction

   // Idle time after an accept: mostly none or short, now and then long.
   // Fields carry junk while start is low; the unit must not take it.
   task automatic idle_after_item(input bit no_gaps);
      int r;
      int gap;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55)
         gap = 0;
      else if (r < 85)
         gap = $urandom_range(1, 3);
      else if (r < 97)
         gap = $urandom_range(4, 10);
      else
         gap = $urandom_range(11, 40);
      if (gap > 0)
         start <= 1'b0;
      for (int i = 0; i < gap; i++) begin
         req_kind       <= KIND_W'($urandom);
         req_item_value <= $urandom;
         req_position   <= POS_W'($urandom);
         @(posedge clock);
      end
   endtask

   // Holds the item on the request ports until an edge with busy low takes it.
   // With no gap, start stays high straight into the next item.
   task automatic issue_item(input req_kind_type kind, input val_type item_val,
                             input logic [POS_W-1:0] pos, input bit typed,
                             input set_result_type typed_res, input bit no_gaps);
      set_result_type res;
      start          <= 1'b1;
      req_kind       <= kind;
      req_item_value <= item_val;
      req_position   <= pos;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      res = apply_to_shadow(kind, item_val, pos);
      pending_results.push_back(typed ? typed_res : res);
      items_sent++;
      idle_after_item(no_gaps);
   endtask

   function automatic val_type pick_value(input int value_mode);
      case (value_mode)
         0: return $urandom;
         1: return val_type'($urandom_range(0, 200)) - 32'sd100;
         default: return corner_values[$urandom_range(0, 5)]
                         + val_type'($urandom_range(0, 2)) - 32'sd1;
      endcase
   endfunction

   // Episode shape: 0 grow, 1 shrink, 2 mixed, 3 noise, 4 fill
   task automatic pick_random_item(input int shape, input int value_mode,
                                   output req_kind_type kind, output val_type item_val,
                                   output logic [POS_W-1:0] pos);
      int r;
      int held;
      r = $urandom_range(0, 99);
      held = shadow_set.size();
      item_val = pick_value(value_mode);
      pos = POS_W'($urandom);
      case (shape)
         0:       kind = (r < 70) ? KIND_INSERT : (r < 78) ? KIND_DELETE :
                         (r < 98) ? KIND_READ : KIND_CLEAR;
         1:       kind = (r < 15) ? KIND_INSERT : (r < 70) ? KIND_DELETE :
                         (r < 97) ? KIND_READ : KIND_CLEAR;
         2:       kind = (r < 35) ? KIND_INSERT : (r < 65) ? KIND_DELETE :
                         (r < 96) ? KIND_READ : KIND_CLEAR;
         3:       kind = req_kind_type'($urandom_range(0, 3));
         default: kind = (r < 95) ? KIND_INSERT : KIND_READ;
      endcase
      if (shape == 3) begin
         item_val = $urandom;  // noise: raw fields, nothing steered
      end else if (kind == KIND_INSERT && held > 0 && $urandom_range(0, 99) < 20) begin
         item_val = shadow_set[$urandom_range(0, held - 1)];
      end else if (kind == KIND_DELETE && held > 0 && $urandom_range(0, 99) < 75) begin
         item_val = shadow_set[$urandom_range(0, held - 1)];
      end else if (kind == KIND_READ && $urandom_range(0, 99) < 75) begin
         pos = POS_W'($urandom_range(0, (held < 63) ? held : 63));
      end
   endtask

   // Result checker: every strobe must match the oldest expectation
   always @(posedge clock) begin : check_results
      set_result_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_results.size() == 0) begin
            flag_mismatch($sformatf("result with none expected, status %0d",
                                    rsp_status));
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            status_seen[want.status]++;
            if (rsp_status !== want.status)
               flag_mismatch($sformatf("status got %0d want %s",
                                       rsp_status, want.status.name()));
            if (rsp_read_data !== want.data)
               flag_mismatch($sformatf("read_data got %0d want %0d",
                                       rsp_read_data, want.data));
            if (rsp_entry_count !== want.count)
               flag_mismatch($sformatf("entry_count got %0d want %0d",
                                       rsp_entry_count, want.count));
         end
      end
   end

   initial begin : stimulus
      req_kind_type kind;
      val_type      item_val;
      logic [POS_W-1:0] pos;
      int           random_sent;
      int           episode;
      int           shape;
      int           value_mode;
      int           run_length;
      bit           no_gaps;
      int           waited;

      error_count     = 0;
      items_sent      = 0;
      results_checked = 0;
      foreach (status_seen[i])
         status_seen[i] = 0;

      reset          <= 1'b1;
      start          <= 1'b0;
      req_kind       <= KIND_INSERT;
      req_item_value <= '0;
      req_position   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      foreach (directed_rows[i])
         issue_item(directed_rows[i].kind, directed_rows[i].item_val, directed_rows[i].pos,
                    directed_rows[i].typed, directed_rows[i].want, 1'b0);

      // Random episodes; the first one fills the set so full and
      // duplicate-when-full come up early
      random_sent = 0;
      episode = 0;
      while (random_sent < RANDOM_ITEMS) begin
         shape      = (episode == 0) ? 4 : $urandom_range(0, 4);
         value_mode = (episode == 0) ? 0 : $urandom_range(0, 2);
         run_length = $urandom_range(40, 200);
         no_gaps    = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < run_length && random_sent < RANDOM_ITEMS; n++) begin
            pick_random_item(shape, value_mode, kind, item_val, pos);
            issue_item(kind, item_val, pos, 1'b0, '0, no_gaps);
            random_sent++;
         end
         episode++;
      end

      if (start !== 1'b0)
         start <= 1'b0;

      // Drain, then a few quiet cycles for any stray strobe
      waited = 0;
      while (pending_results.size() > 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (6) @(posedge clock);
      if (pending_results.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));

      $display("Ran %0d items in %0d episodes, %0d results checked.",
               items_sent, episode, results_checked);
      $display("Inserted %0d, duplicates %0d, full %0d, deleted %0d, absent %0d, reads %0d/%0d.",
               status_seen[ST_INSERTED], status_seen[ST_DUPLICATE], status_seen[ST_FULL],
               status_seen[ST_DELETED], status_seen[ST_NOT_FOUND],
               status_seen[ST_READ_OK], status_seen[ST_BAD_POS]);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
